// ===== rtl/w19937_pkg.sv =====
// Shared types, constants and helper functions for the WELL19937 word generator.
// Depends on nothing; every other file in rtl except w19937_ram imports it.
package w19937_pkg;

    // Store geometry: a block is STORE_WORDS requests, the store holds one word fewer.
    localparam int STORE_WORDS = 624;
    localparam int LIVE_WORDS  = STORE_WORDS - 1;
    localparam int POS_W       = $clog2(STORE_WORDS);
    localparam int ADDR_W      = $clog2(LIVE_WORDS);
    localparam int WORD_W      = 32;

    // Recursion lags, in the order the mixing logic expects them.
    localparam int LAG_COUNT = 5;
    localparam int LAG_IDX_A  = 0;
    localparam int LAG_IDX_B  = 1;
    localparam int LAG_IDX_M1 = 2;
    localparam int LAG_IDX_M2 = 3;
    localparam int LAG_IDX_M3 = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam addr_t LAG_TABLE [LAG_COUNT] = '{
        addr_t'(1), addr_t'(2), addr_t'(553), addr_t'(444), addr_t'(174)
    };

    // Tempering masks and the reset value of the seed register.
    localparam word_t TEMPER_B   = 32'he46e1700;
    localparam word_t TEMPER_C   = 32'h9b868000;
    localparam word_t SEED_RESET = 32'h95f24dab;

    // Initial contents of the low store words; word 0 is replaced by the seed.
    localparam int TABLE_WORDS = 25;
    localparam int TABLE_IDX_W = $clog2(TABLE_WORDS);
    localparam word_t SEED_TABLE [TABLE_WORDS] = '{
        32'h95f24dab, 32'h0b685215, 32'he76ccae7, 32'haf3ec239, 32'h715fad23,
        32'h24a590ad, 32'h69e4b5ef, 32'hbf456141, 32'h96bc1b7b, 32'ha7bdf825,
        32'hc1de75b7, 32'h8858a9c9, 32'h2da87693, 32'hb657f9dd, 32'hffdc8a9f,
        32'h8121da71, 32'h8b823ecb, 32'h885d05f5, 32'h4e20cd47, 32'h5a9ad5d9,
        32'h512c0c03, 32'hea857ccd, 32'h4cc1d30f, 32'h8891a8a1, 32'ha6b7aadb
    };

    // Read requests for the five lagged words of one item.
    typedef struct packed {
        logic [LAG_COUNT-1:0][ADDR_W-1:0] addr;
        logic [LAG_COUNT-1:0]             use_ram;
        logic [LAG_COUNT-1:0][WORD_W-1:0] init;
    } lag_req_t;

    // Store word as it stands after a reload.
    function automatic word_t init_word(input addr_t a, input word_t seed);
        word_t w;
        if (a == '0) begin
            w = seed;
        end else if (a < addr_t'(TABLE_WORDS)) begin
            w = SEED_TABLE[a[TABLE_IDX_W-1:0]];
        end else begin
            w = '0;
        end
        return w;
    endfunction

    // Position plus lag, wrapped into the live store.
    function automatic addr_t lagged_addr(input pos_t pos, input addr_t lag);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + {{(POS_W + 1 - ADDR_W){1'b0}}, lag};
        if (sum >= (POS_W + 1)'(LIVE_WORDS)) begin
            sum = sum - (POS_W + 1)'(LIVE_WORDS);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Output tempering.
    function automatic word_t temper(input word_t y);
        word_t t;
        t = y ^ ((y << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        return t;
    endfunction

endpackage

// ===== rtl/w19937_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module w19937_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 623
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds while rd_en is low.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/w19937_lag_gen.sv =====
// Address generation for the five lagged reads, with the reload values they fall back on.
// Depends on w19937_pkg.
module w19937_lag_gen (
    input  w19937_pkg::pos_t     pos,
    input  logic                 raw,
    input  logic                 filled,
    input  w19937_pkg::word_t    seed,
    output w19937_pkg::lag_req_t req,
    output w19937_pkg::word_t    direct_word
);
    import w19937_pkg::*;

    // Each lag gets its wrapped address. An entry has been rewritten since the last
    // reload once a whole advancing block has run, or when it lies below the
    // current position of the first advancing block; otherwise its reload value stands.
    always_comb begin
        for (int i = 0; i < LAG_COUNT; i++) begin
            req.addr[i]    = lagged_addr(pos, LAG_TABLE[i]);
            req.use_ram[i] = !raw && (filled || ({1'b0, req.addr[i]} < {1'b0, pos}));
            req.init[i]    = init_word(req.addr[i], seed);
        end
    end

    // During a raw block the store is never written, so the word is its reload value.
    assign direct_word = init_word(pos[ADDR_W-1:0], seed);

endmodule

// ===== rtl/w19937_mix.sv =====
// Recursion step: selects the lagged words and computes the new word and the next carry.
// Depends on w19937_pkg.
module w19937_mix (
    input  logic [w19937_pkg::LAG_COUNT-1:0][w19937_pkg::WORD_W-1:0] ram_data,
    input  logic [w19937_pkg::LAG_COUNT-1:0]                         use_ram,
    input  logic [w19937_pkg::LAG_COUNT-1:0][w19937_pkg::WORD_W-1:0] init_data,
    input  w19937_pkg::word_t                                        carry,
    output w19937_pkg::word_t                                        new_word,
    output w19937_pkg::word_t                                        carry_next
);
    import w19937_pkg::*;

    word_t sel [LAG_COUNT];
    word_t z0;
    word_t z1;
    word_t z2;

    // Each lagged word comes from the store unless the entry still holds its reload value.
    always_comb begin
        for (int i = 0; i < LAG_COUNT; i++) begin
            sel[i] = use_ram[i] ? ram_data[i] : init_data[i];
        end
    end

    // Linear mixing of the lagged words and the carry.
    always_comb begin
        z0 = {sel[LAG_IDX_A][WORD_W-1], sel[LAG_IDX_B][WORD_W-2:0]};
        z1 = (carry ^ (carry << 25)) ^ (sel[LAG_IDX_M1] ^ (sel[LAG_IDX_M1] >> 27));
        z2 = (sel[LAG_IDX_M2] >> 9) ^ (sel[LAG_IDX_M3] ^ (sel[LAG_IDX_M3] >> 1));
        new_word   = z1 ^ z2;
        carry_next = z0 ^ (z1 ^ (z1 << 9)) ^ (z2 ^ (z2 << 21))
                   ^ (new_word ^ (new_word >> 21));
    end

endmodule

// ===== rtl/well19937_word_generator.sv =====
// Top level of the WELL19937 word generator: control, read pipeline, store and output.
// Depends on w19937_pkg, w19937_ram, w19937_lag_gen and w19937_mix.
//
//   channel   ports                           moves
//   input     s_valid, s_ready, s_request     one request item
//   output    m_valid, m_ready, m_random_word one tempered word
//   config    seed_wr_en, seed_wr_data        seed write, no handshake
//
// A request item is accepted and its five lagged reads are issued at the same edge; the
// word then passes through the read stage register into the output register. One word
// per cycle is sustained while the output is not stalled, set by the five replicated
// store memories (one read port each) and the carry update. A request of zero is
// accepted and yields nothing. Reset and a seed write reload the store logically through
// a fill flag, with no clearing pass.
// While an output item waits, one further request item can still be accepted.
module well19937_word_generator (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_request,
    output logic              m_valid,
    input  logic              m_ready,
    output w19937_pkg::word_t m_random_word,
    input  logic              seed_wr_en,
    input  w19937_pkg::word_t seed_wr_data
);
    import w19937_pkg::*;

    // Control state.
    word_t    seed_reg,   seed_next;
    pos_t     pos_reg,    pos_next;
    logic     raw_reg,    raw_next;
    logic     filled_reg, filled_next;
    word_t    carry_reg,  carry_next;

    // Read stage.
    logic     s1_valid_reg, s1_valid_next;
    pos_t     s1_pos_reg;
    logic     s1_raw_reg;
    logic [LAG_COUNT-1:0]             s1_use_ram_reg;
    logic [LAG_COUNT-1:0][WORD_W-1:0] s1_init_reg;
    word_t    s1_direct_reg;

    // Output register.
    logic     m_valid_reg, m_valid_next;
    word_t    m_word_reg;

    lag_req_t lag_req;
    word_t    direct_word;
    logic [LAG_COUNT-1:0][WORD_W-1:0] ram_rd_data;
    word_t    new_word;
    word_t    mix_carry;
    word_t    s1_word;
    logic     s1_fire;
    logic     s1_advance;
    logic     accept;
    logic     start;

    // Handshake: the read stage drains into the output register when that is free.
    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign accept  = s_valid && s_ready;
    assign start   = accept && s_request;

    // The stage writes the store only for recursion positions of an advancing block.
    assign s1_advance = !s1_raw_reg && (s1_pos_reg != pos_t'(LIVE_WORDS));

    w19937_lag_gen u_lag_gen (
        .pos        (pos_reg),
        .raw        (raw_reg),
        .filled     (filled_reg),
        .seed       (seed_reg),
        .req        (lag_req),
        .direct_word(direct_word)
    );

    // One store copy per lag, all written with the same new word.
    for (genvar g = 0; g < LAG_COUNT; g++) begin : g_store
        w19937_ram #(
            .WIDTH(WORD_W),
            .DEPTH(LIVE_WORDS)
        ) u_ram (
            .aclk   (aclk),
            .wr_en  (s1_fire && s1_advance),
            .wr_addr(s1_pos_reg[ADDR_W-1:0]),
            .wr_data(new_word),
            .rd_en  (start),
            .rd_addr(lag_req.addr[g]),
            .rd_data(ram_rd_data[g])
        );
    end

    w19937_mix u_mix (
        .ram_data  (ram_rd_data),
        .use_ram   (s1_use_ram_reg),
        .init_data (s1_init_reg),
        .carry     (carry_reg),
        .new_word  (new_word),
        .carry_next(mix_carry)
    );

    // The last request of a block returns the carry; a raw block returns reload values.
    always_comb begin
        if (s1_pos_reg == pos_t'(LIVE_WORDS)) begin
            s1_word = carry_reg;
        end else if (s1_raw_reg) begin
            s1_word = s1_direct_reg;
        end else begin
            s1_word = new_word;
        end
    end

    // Next-state logic for position, block flags, seed and carry.
    always_comb begin
        seed_next   = seed_reg;
        pos_next    = pos_reg;
        raw_next    = raw_reg;
        filled_next = filled_reg;
        carry_next  = carry_reg;
        if (seed_wr_en) begin
            seed_next   = seed_wr_data;
            pos_next    = '0;
            raw_next    = 1'b1;
            filled_next = 1'b0;
            carry_next  = '0;
        end else begin
            if (start) begin
                if (pos_reg == pos_t'(LIVE_WORDS)) begin
                    pos_next = '0;
                    raw_next = 1'b0;
                    if (!raw_reg) begin
                        filled_next = 1'b1;
                    end
                end else begin
                    pos_next = pos_reg + pos_t'(1);
                end
            end
            if (s1_fire && s1_advance) begin
                carry_next = mix_carry;
            end
        end
    end

    // Valid flags of the read stage and the output register.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (start) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg     <= SEED_RESET;
            pos_reg      <= '0;
            raw_reg      <= 1'b1;
            filled_reg   <= 1'b0;
            carry_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            seed_reg     <= seed_next;
            pos_reg      <= pos_next;
            raw_reg      <= raw_next;
            filled_reg   <= filled_next;
            carry_reg    <= carry_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers of the read stage and the output.
    always_ff @(posedge aclk) begin
        if (start) begin
            s1_pos_reg     <= pos_reg;
            s1_raw_reg     <= raw_reg;
            s1_use_ram_reg <= lag_req.use_ram;
            s1_init_reg    <= lag_req.init;
            s1_direct_reg  <= direct_word;
        end
        if (s1_fire) begin
            m_word_reg <= temper(s1_word);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_random_word = m_word_reg;

endmodule

// ===== rtl/w19937_checker.sv =====
// Port-level checks on the WELL19937 word generator, bound to its top level.
// Depends on w19937_pkg and well19937_word_generator.
module w19937_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_request,
    input logic              m_valid,
    input logic              m_ready,
    input w19937_pkg::word_t m_random_word
);
    import w19937_pkg::*;

    // Reset leaves no item in the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output item present after reset");

    // A stalled output item keeps its word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_word))
        else $error("stalled output item changed");

    // The input side is held off only while an output item is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input held off without a stalled output item");

    // A request taken during a stall fills the read stage, so the input then
    // follows the output's ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && s_valid && s_ready && s_request |=> s_ready == m_ready)
        else $error("read stage did not hold the request taken during a stall");

endmodule

bind well19937_word_generator w19937_checker u_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_request    (s_request),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_random_word(m_random_word)
);
